// File: src/dia_pkg.sv
package dia_pkg;

   // shared multiplier operand width
   localparam int MUL_W = 32;

   // temperature factor entries, unsigned Q10.16
   localparam int FACTOR_W = 26;

   // exact division by 127 for values below 2^31: ceil(2^38 / 127)
   localparam logic [31:0] WET_RECIP = 32'd2164392969;
   localparam int          WET_SHIFT = 38;
   localparam int          Q0_W      = 13;

   // annual index: round(2^16 * sum / (292000 * 2^f)) as floor((n >> 5) / 9125)
   localparam logic [31:0] ANN_RECIP = 32'd1927910800;
   localparam int          ANN_SHIFT = 44;
   localparam logic [63:0] ANN_ROUND = 64'd146000;
   localparam logic [63:0] ANN_LIMIT = 64'd19136512000;

   localparam logic [63:0] Q24_ONE = 64'd1 << 24;

   typedef enum logic [3:0] {
      IDLE,
      WET_DIV,
      WET_REM,
      WET_APPLY,
      ROOM_LO,
      ROOM_HI,
      ROUND_P,
      DRY_LO,
      DRY_HI,
      DRY_ADD,
      SUM_ADD,
      ANN_MUL,
      ANN_RES,
      EMIT
   } state_type;

   // exp(x) for x in q.24: series of exp(x/8) to the 20th term, squared thrice
   function automatic logic [63:0] exp_q24(input logic [63:0] x);
      logic [63:0] y;
      logic [63:0] term;
      logic [63:0] acc;
      int          k;
      y    = x >> 3;
      term = Q24_ONE;
      acc  = Q24_ONE;
      term = ((term * y) >> 24) / 64'd1;  acc = acc + term;
      term = ((term * y) >> 24) / 64'd2;  acc = acc + term;
      term = ((term * y) >> 24) / 64'd3;  acc = acc + term;
      term = ((term * y) >> 24) / 64'd4;  acc = acc + term;
      term = ((term * y) >> 24) / 64'd5;  acc = acc + term;
      term = ((term * y) >> 24) / 64'd6;  acc = acc + term;
      term = ((term * y) >> 24) / 64'd7;  acc = acc + term;
      term = ((term * y) >> 24) / 64'd8;  acc = acc + term;
      term = ((term * y) >> 24) / 64'd9;  acc = acc + term;
      term = ((term * y) >> 24) / 64'd10; acc = acc + term;
      term = ((term * y) >> 24) / 64'd11; acc = acc + term;
      term = ((term * y) >> 24) / 64'd12; acc = acc + term;
      term = ((term * y) >> 24) / 64'd13; acc = acc + term;
      term = ((term * y) >> 24) / 64'd14; acc = acc + term;
      term = ((term * y) >> 24) / 64'd15; acc = acc + term;
      term = ((term * y) >> 24) / 64'd16; acc = acc + term;
      term = ((term * y) >> 24) / 64'd17; acc = acc + term;
      term = ((term * y) >> 24) / 64'd18; acc = acc + term;
      term = ((term * y) >> 24) / 64'd19; acc = acc + term;
      term = ((term * y) >> 24) / 64'd20; acc = acc + term;
      for (k = 0; k < 3; k++) begin
         acc = (acc * acc + (Q24_ONE >> 1)) >> 24;
      end
      return acc;
   endfunction

   // drying factor at t tenths of a degree, floored at zero, rounded to q.16
   function automatic logic [FACTOR_W-1:0] temp_factor(input int unsigned t);
      logic [63:0] num;
      logic [63:0] x;
      logic [63:0] e;
      logic [63:0] a;
      logic [63:0] b;
      logic [63:0] f;
      num = 64'd8748 * 64'(t) + 64'd1555200;
      x   = ((num << 24) + 64'd500000) / 64'd1000000;
      e   = exp_q24(x);
      a   = (e * 64'd9676 + 64'd5000) / 64'd10000;
      b   = ((64'd8299 << 24) + 64'd500) / 64'd1000;
      f   = (a > b) ? ((a - b + 64'd128) >> 8) : 64'd0;
      return f[FACTOR_W-1:0];
   endfunction

endpackage

// File: src/dia_mul.sv
module dia_mul
   import dia_pkg::*;
(
   input  logic                 clock,
   input  logic [MUL_W-1:0]     operand_a,
   input  logic [MUL_W-1:0]     operand_b,
   output logic [2*MUL_W-1:0]   product
);

   logic [2*MUL_W-1:0] product_ff;
   logic [2*MUL_W-1:0] product_in;

   // one full-width product per cycle, registered
   assign product_in = (2*MUL_W)'(operand_a) * (2*MUL_W)'(operand_b);

   always_ff @(posedge clock) begin
      product_ff <= product_in;
   end

   assign product = product_ff;

endmodule

// File: src/drought_index_accumulator.sv
// sequence: a day is accepted in idle and runs through the wetting steps, the
// drying steps when drying applies, the annual steps on a last day, then emit,
// which registers its word once the output is free; a new day is taken only in idle,
// and the single 32x32 multiplier carries up to seven products of a day in turn (wetting, drying, annual)
// reset (synchronous): index 100, sum 0, drying_scale 360800, output empty
module drought_index_accumulator
   import dia_pkg::*;
#(
   parameter int TEMP_TABLE_ENTRIES = 512,
   parameter int FRAC_BITS          = 16
) (
   input  logic        clock,
   input  logic        reset,
   // rain_tenth_mm [13:0], max_temp_tenth_c [24:14], snow_present [25]
   input  logic [31:0] req_tdata,
   // first_day
   input  logic        req_tuser,
   input  logic        req_tlast,
   input  logic        req_tvalid,
   output logic        req_tready,
   // index_today [25:0], annual_relative_index [41:26]
   output logic [47:0] rsp_tdata,
   // annual_valid
   output logic        rsp_tuser,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   localparam int LEVEL_W    = FRAC_BITS + 10;
   localparam int SUM_W      = FRAC_BITS + 19;
   localparam int WET_W      = FRAC_BITS + 13;
   localparam int P_W        = FRAC_BITS + 20;
   localparam int ADDR_W     = $clog2(TEMP_TABLE_ENTRIES);
   localparam int TSTEP      = (500 + TEMP_TABLE_ENTRIES - 1) / TEMP_TABLE_ENTRIES;
   localparam int ADDR_RECIP = ((1 << 12) + TSTEP - 1) / TSTEP;

   localparam logic [LEVEL_W-1:0] LEVEL_MAX   = LEVEL_W'(800) << FRAC_BITS;
   localparam logic [LEVEL_W-1:0] LEVEL_START = LEVEL_W'(100) << FRAC_BITS;
   localparam logic [SUM_W-1:0]   SUM_MAX     = '1;
   localparam logic [22:0]        SCALE_RESET = 23'd360800;
   localparam logic               CSR_DRYING_SCALE = 1'b0;

   state_type state_ff, state_in;

   logic [LEVEL_W-1:0]  level_ff, level_in;
   logic [SUM_W-1:0]    sum_ff, sum_in;
   logic [22:0]         scale_ff, scale_in;
   logic [19:0]         y_ff, y_in;
   logic [Q0_W-1:0]     q0_ff, q0_in;
   logic [63:0]         acc_ff, acc_in;
   logic [P_W-1:0]      p_ff, p_in;
   logic [15:0]         annual_ff, annual_in;
   logic                dry_ff, dry_in;
   logic                last_ff, last_in;
   logic [ADDR_W-1:0]   addr_ff, addr_in;
   logic [FACTOR_W-1:0] factor_ff;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [25:0]         rsp_index_ff, rsp_index_in;
   logic [15:0]         rsp_annual_ff, rsp_annual_in;
   logic                rsp_flag_ff, rsp_flag_in;

   logic [MUL_W-1:0]    mul_a;
   logic [MUL_W-1:0]    mul_b;
   logic [2*MUL_W-1:0]  mul_product;

   logic                req_accept;
   logic                csr_write;

   // temperature rom, built at elaboration, read through a register
   logic [FACTOR_W-1:0] temp_rom [TEMP_TABLE_ENTRIES];

   for (genvar g = 0; g < TEMP_TABLE_ENTRIES; g++) begin : g_rom
      localparam int RawT = 101 + g * TSTEP;
      localparam int RomT = (RawT > 600) ? 600 : RawT;
      assign temp_rom[g] = temp_factor(RomT);
   end

   always_ff @(posedge clock) begin
      factor_ff <= temp_rom[addr_ff];
   end

   dia_mul u_mul (
      .clock     (clock),
      .operand_a (mul_a),
      .operand_b (mul_b),
      .product   (mul_product)
   );

   // input word fields and rom address
   logic [13:0]        req_rain;
   logic signed [10:0] req_temp;
   logic signed [10:0] temp_clip;
   logic               req_hot;
   logic [8:0]         temp_offset;
   logic [21:0]        addr_prod;
   logic [9:0]         addr_idx;

   assign req_rain    = req_tdata[13:0];
   assign req_temp    = req_tdata[24:14];
   assign req_hot     = req_temp > 11'sd100;
   assign temp_clip   = (req_temp > 11'sd600) ? 11'sd600 : req_temp;
   assign temp_offset = req_hot ? 9'(temp_clip - 11'sd101) : 9'd0;
   assign addr_prod   = 22'(temp_offset) * 22'(ADDR_RECIP);
   assign addr_idx    = (addr_prod[21:12] > 10'(TEMP_TABLE_ENTRIES - 1)) ?
                        10'(TEMP_TABLE_ENTRIES - 1) : addr_prod[21:12];

   // wetting: rain*50*2^f divided by 127 in two exact reciprocal passes
   logic [Q0_W-1:0]      q0_now;
   logic [6:0]           r0;
   logic [31:0]          z_op;
   logic [FRAC_BITS-1:0] q1_now;
   logic [WET_W-1:0]     wet;

   assign q0_now = mul_product[WET_SHIFT +: Q0_W];
   assign r0     = 7'(y_ff - (20'({q0_now, 7'd0}) - 20'(q0_now)));
   assign z_op   = (32'(r0) << FRAC_BITS) + 32'd63;
   assign q1_now = mul_product[WET_SHIFT +: FRAC_BITS];
   assign wet    = (WET_W'(q0_ff) << FRAC_BITS) + WET_W'(q1_now);

   // drying: room times factor, then times drying_scale over 2^32
   logic [LEVEL_W-1:0] room;
   logic [63:0]        room64;
   logic [63:0]        p_sum;
   logic [63:0]        p64;
   logic [63:0]        dq;
   logic [63:0]        dried;

   assign room   = (level_ff < LEVEL_MAX) ? (LEVEL_MAX - level_ff) : '0;
   assign room64 = 64'(room);
   assign p_sum  = acc_ff + (mul_product << 32) + 64'h8000;
   assign p64    = 64'(p_ff);
   assign dq     = mul_product + ((acc_ff + 64'h8000_0000) >> 32);
   assign dried  = 64'(level_ff) + dq;

   // running sum and annual numerator
   logic [SUM_W:0] sum_wide;
   logic [63:0]    ann_num;
   logic           ann_sat;

   assign sum_wide = (SUM_W + 1)'(sum_ff) + (SUM_W + 1)'(level_ff);
   assign ann_num  = ((64'(sum_ff) << 16) >> FRAC_BITS) + ANN_ROUND;
   assign ann_sat  = ann_num >= ANN_LIMIT;

   assign req_tready = (state_ff == IDLE);
   assign req_accept = req_tvalid && req_tready;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;

   // sequencer: next state, multiplier operands and datapath updates
   always_comb begin
      state_in      = state_ff;
      level_in      = level_ff;
      sum_in        = sum_ff;
      scale_in      = scale_ff;
      y_in          = y_ff;
      q0_in         = q0_ff;
      acc_in        = acc_ff;
      p_in          = p_ff;
      annual_in     = annual_ff;
      dry_in        = dry_ff;
      last_in       = last_ff;
      addr_in       = addr_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_index_in  = rsp_index_ff;
      rsp_annual_in = rsp_annual_ff;
      rsp_flag_in   = rsp_flag_ff;
      mul_a         = '0;
      mul_b         = '0;

      if (csr_write && (csr_paddr[2] == CSR_DRYING_SCALE)) begin
         scale_in = csr_pwdata[22:0];
      end

      case (state_ff)
         IDLE: begin
            if (req_accept) begin
               y_in    = 20'(req_rain) * 20'd50;
               dry_in  = req_hot && !req_tdata[25];
               last_in = req_tlast;
               addr_in = ADDR_W'(addr_idx);
               if (req_tuser) begin
                  level_in = LEVEL_START;
                  sum_in   = '0;
               end
               state_in = WET_DIV;
            end
         end
         WET_DIV: begin
            mul_a    = 32'(y_ff);
            mul_b    = WET_RECIP;
            state_in = WET_REM;
         end
         WET_REM: begin
            q0_in    = q0_now;
            mul_a    = z_op;
            mul_b    = WET_RECIP;
            state_in = WET_APPLY;
         end
         WET_APPLY: begin
            level_in = (wet >= WET_W'(level_ff)) ? '0 : LEVEL_W'(WET_W'(level_ff) - wet);
            state_in = dry_ff ? ROOM_LO : SUM_ADD;
         end
         ROOM_LO: begin
            mul_a    = room64[31:0];
            mul_b    = 32'(factor_ff);
            state_in = ROOM_HI;
         end
         ROOM_HI: begin
            acc_in   = mul_product;
            mul_a    = room64[63:32];
            mul_b    = 32'(factor_ff);
            state_in = ROUND_P;
         end
         ROUND_P: begin
            p_in     = P_W'(p_sum >> 16);
            state_in = DRY_LO;
         end
         DRY_LO: begin
            mul_a    = p64[31:0];
            mul_b    = 32'(scale_ff);
            state_in = DRY_HI;
         end
         DRY_HI: begin
            acc_in   = mul_product;
            mul_a    = p64[63:32];
            mul_b    = 32'(scale_ff);
            state_in = DRY_ADD;
         end
         DRY_ADD: begin
            level_in = (dried > 64'(LEVEL_MAX)) ? LEVEL_MAX : LEVEL_W'(dried);
            state_in = SUM_ADD;
         end
         SUM_ADD: begin
            sum_in   = sum_wide[SUM_W] ? SUM_MAX : sum_wide[SUM_W-1:0];
            state_in = last_ff ? ANN_MUL : EMIT;
         end
         ANN_MUL: begin
            mul_a    = ann_num[36:5];
            mul_b    = ANN_RECIP;
            state_in = ANN_RES;
         end
         ANN_RES: begin
            annual_in = ann_sat ? 16'hFFFF : mul_product[ANN_SHIFT +: 16];
            state_in  = EMIT;
         end
         EMIT: begin
            // wait for the output register to be free
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in  = 1'b1;
               rsp_index_in  = 26'(64'(level_ff));
               rsp_annual_in = last_ff ? annual_ff : 16'd0;
               rsp_flag_in   = last_ff;
               state_in      = IDLE;
            end
         end
         default: begin
            state_in = IDLE;
         end
      endcase
   end

   // control and state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= IDLE;
         level_ff     <= LEVEL_START;
         sum_ff       <= '0;
         scale_ff     <= SCALE_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         level_ff     <= level_in;
         sum_ff       <= sum_in;
         scale_ff     <= scale_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      y_ff          <= y_in;
      q0_ff         <= q0_in;
      acc_ff        <= acc_in;
      p_ff          <= p_in;
      annual_ff     <= annual_in;
      dry_ff        <= dry_in;
      last_ff       <= last_in;
      addr_ff       <= addr_in;
      rsp_index_ff  <= rsp_index_in;
      rsp_annual_ff <= rsp_annual_in;
      rsp_flag_ff   <= rsp_flag_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {6'd0, rsp_annual_ff, rsp_index_ff};
   assign rsp_tuser  = rsp_flag_ff;

   assign csr_pready = 1'b1;
   assign csr_prdata = (csr_paddr[2] == CSR_DRYING_SCALE) ? 32'(scale_ff) : 32'd0;

   // index stays within its saturation bound
   assert property (@(posedge clock) disable iff (reset)
      level_ff <= LEVEL_MAX)
      else $error("drought index above its maximum");

   // a first day restarts the index and the sum
   assert property (@(posedge clock) disable iff (reset)
      req_accept && req_tuser |=> (level_ff == LEVEL_START) && (sum_ff == '0))
      else $error("first day did not restart the year");

   // a result word is only launched from the emit step
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == EMIT))
      else $error("result word launched outside emit");

   // the annual field is zero on days that are not a year end
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_flag_ff |-> rsp_annual_ff == 16'd0)
      else $error("annual field set on an ordinary day");

endmodule
